// ===== hw/rtl/spf_pkg.sv =====
// shared types and constants of the segment proximity point filter
package spf_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5,
        REG_RADIUS  = 3'd6
    } cfg_reg_t;

    // reset segment and radius, q7.16 metres
    localparam int RST_START_X = -3146;
    localparam int RST_START_Y = 42101;
    localparam int RST_START_Z = 42074;
    localparam int RST_END_X   = -3146;
    localparam int RST_END_Y   = 42101;
    localparam int RST_END_Z   = 79561;
    localparam int RST_RADIUS  = 6554;

    // control that travels beside the geometry data
    typedef struct packed {
        logic valid;
        logic origin;
    } spf_ctl_t;

endpackage

// ===== hw/rtl/spf_wide_mul.sv =====
// unsigned wide multiplier split into half-width partial products over two stages
module spf_wide_mul #(
    parameter int W = 50
) (
    input  logic           clk,
    input  logic           en,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] p
);

    localparam int H  = (W + 1) / 2;
    localparam int HW = W - H;

    logic [2*H-1:0]    ll_reg, ll_next;
    logic [H+HW-1:0]   lh_reg, lh_next;
    logic [H+HW-1:0]   hl_reg, hl_next;
    logic [2*HW-1:0]   hh_reg, hh_next;
    logic [2*W-1:0]    p_reg, p_next;

    // stage a: four partial products
    always_comb
    begin
        ll_next = a[H-1:0] * b[H-1:0];
        lh_next = a[H-1:0] * b[W-1:H];
        hl_next = a[W-1:H] * b[H-1:0];
        hh_next = a[W-1:H] * b[W-1:H];
    end

    // stage b: recombine
    always_comb
    begin
        p_next = {hh_reg, ll_reg}
               + ((2*W)'(lh_reg) << H)
               + ((2*W)'(hl_reg) << H);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/spf_skid.sv =====
// output register with a skid word so the input ready comes from a flop
module spf_skid #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    logic [W-1:0] out_data_reg, out_data_next;
    logic [W-1:0] skid_data_reg, skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            // output stalled: park the incoming word
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/spf_geom.sv =====
// first four pipeline stages: differences, products, sums, magnitudes and window limits
module spf_geom #(
    parameter int N = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [N-1:0]   pt [3],
    input  logic signed [N-1:0]   seg_a [3],
    input  logic signed [N-1:0]   seg_b [3],
    input  logic [N-2:0]          radius,
    output spf_pkg::spf_ctl_t     ctl,
    output logic signed [N-1:0]   pt_out [3],
    output logic signed [2*N+9:0] dp20,
    output logic signed [2*N+9:0] lim_lo,
    output logic signed [2*N+9:0] lim_hi,
    output logic [2*N+1:0]        c_abs [3],
    output logic [2*N+1:0]        len2,
    output logic [2*N+1:0]        rr
);

    import spf_pkg::*;

    localparam int D  = N + 1;      // difference width
    localparam int P  = 2 * D;      // product width
    localparam int XW = 2 * N + 10; // window compare width

    // stage 1
    logic                v1_reg, origin1_reg, origin1_next;
    logic signed [N-1:0] pt1_reg [3];
    logic signed [D-1:0] w1_reg [3], w1_next [3];
    logic signed [D-1:0] d1_reg [3], d1_next [3];
    logic [N-2:0]        rad1_reg;

    // stage 2
    logic                v2_reg, origin2_reg;
    logic signed [N-1:0] pt2_reg [3];
    logic signed [P-1:0] pwd_reg [3][3], pwd_next [3][3];
    logic signed [P-1:0] dd_reg [3], dd_next [3];
    logic [2*N-3:0]      rr2_reg, rr2_next;

    // stage 3
    logic                  v3_reg, origin3_reg;
    logic signed [N-1:0]   pt3_reg [3];
    logic signed [P+1:0]   dp3_reg, dp3_next;
    logic signed [P:0]     c3_reg [3], c3_next [3];
    logic [P-1:0]          len3_reg, len3_next;
    logic [2*N-3:0]        rr3_reg;

    // stage 4
    logic                  v4_reg, origin4_reg;
    logic signed [N-1:0]   pt4_reg [3];
    logic signed [XW-1:0]  dp20_reg, dp20_next;
    logic signed [XW-1:0]  lo_reg, lo_next;
    logic signed [XW-1:0]  hi_reg, hi_next;
    logic [P-1:0]          cabs_reg [3], cabs_next [3];
    logic [P-1:0]          len4_reg;
    logic [P-1:0]          rr4_reg;

    logic signed [P:0]     c_neg [3];
    logic signed [XW-1:0]  dp_x, len_x;

    // stage 1: offsets from the first endpoint
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            w1_next[i] = $signed({pt[i][N-1], pt[i]}) - $signed({seg_a[i][N-1], seg_a[i]});
            d1_next[i] = $signed({seg_b[i][N-1], seg_b[i]})
                       - $signed({seg_a[i][N-1], seg_a[i]});
        end
        origin1_next = (pt[0] == '0) && (pt[1] == '0) && (pt[2] == '0);
    end

    // stage 2: all pairwise products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pwd_next[i][j] = w1_reg[i] * d1_reg[j];
            end
            dd_next[i] = d1_reg[i] * d1_reg[i];
        end
        rr2_next = rad1_reg * rad1_reg;
    end

    // stage 3: dot product, cross product, squared length
    always_comb
    begin
        dp3_next = $signed({{2{pwd_reg[0][0][P-1]}}, pwd_reg[0][0]})
                 + $signed({{2{pwd_reg[1][1][P-1]}}, pwd_reg[1][1]})
                 + $signed({{2{pwd_reg[2][2][P-1]}}, pwd_reg[2][2]});
        c3_next[0] = $signed({pwd_reg[1][2][P-1], pwd_reg[1][2]})
                   - $signed({pwd_reg[2][1][P-1], pwd_reg[2][1]});
        c3_next[1] = $signed({pwd_reg[2][0][P-1], pwd_reg[2][0]})
                   - $signed({pwd_reg[0][2][P-1], pwd_reg[0][2]});
        c3_next[2] = $signed({pwd_reg[0][1][P-1], pwd_reg[0][1]})
                   - $signed({pwd_reg[1][0][P-1], pwd_reg[1][0]});
        // squares are non-negative and below 2^(2N)
        len3_next = P'(dd_reg[0][2*N-1:0]) + P'(dd_reg[1][2*N-1:0])
                  + P'(dd_reg[2][2*N-1:0]);
    end

    // stage 4: cross magnitudes and scaled window limits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_neg[i]     = -c3_reg[i];
            cabs_next[i] = c3_reg[i][P] ? c_neg[i][P-1:0] : c3_reg[i][P-1:0];
        end
        dp_x      = $signed({{(XW-P-2){dp3_reg[P+1]}}, dp3_reg});
        len_x     = $signed({{(XW-P){1'b0}}, len3_reg});
        dp20_next = (dp_x <<< 4) + (dp_x <<< 2);
        hi_next   = (len_x <<< 4) + (len_x <<< 2) + (len_x <<< 1) + len_x;
        lo_next   = -((len_x <<< 1) + len_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg      <= w1_next;
            d1_reg      <= d1_next;
            pt1_reg     <= pt;
            origin1_reg <= origin1_next;
            rad1_reg    <= radius;

            pwd_reg     <= pwd_next;
            dd_reg      <= dd_next;
            rr2_reg     <= rr2_next;
            pt2_reg     <= pt1_reg;
            origin2_reg <= origin1_reg;

            dp3_reg     <= dp3_next;
            c3_reg      <= c3_next;
            len3_reg    <= len3_next;
            rr3_reg     <= rr2_reg;
            pt3_reg     <= pt2_reg;
            origin3_reg <= origin2_reg;

            cabs_reg    <= cabs_next;
            dp20_reg    <= dp20_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            len4_reg    <= len3_reg;
            rr4_reg     <= P'(rr3_reg);
            pt4_reg     <= pt3_reg;
            origin4_reg <= origin3_reg;
        end
    end

    assign ctl.valid  = v4_reg;
    assign ctl.origin = origin4_reg;
    assign pt_out     = pt4_reg;
    assign dp20       = dp20_reg;
    assign lim_lo     = lo_reg;
    assign lim_hi     = hi_reg;
    assign c_abs      = cabs_reg;
    assign len2       = len4_reg;
    assign rr         = rr4_reg;

endmodule

// ===== hw/rtl/segment_proximity_point_filter.sv =====
// top level of the segment proximity point filter
// Each word on s_axis is one 3D point (x, y, z, signed fixed point, q7.16 metres at the
// default width); each word on m_axis returns the same point unchanged with a keep flag in
// tuser. A point is dropped (keep = 0) when its projection onto the line through the
// configured segment falls strictly between -0.15 and 1.15 of the segment length and it
// lies within keepout_radius of that line, or when it is exactly the origin inside that
// window; a zero-length segment keeps every point. All tests are exact integer compares,
// with no rounding. The block takes one point per clock while s_axis_tready is high and
// returns one result per point, in order, through eight register stages: four geometry
// stages, two stages of the split wide multipliers that square the cross product and
// scale the radius, one summing stage and the output register. The first stage loads on
// the accepting edge, and the result word is offered on m_axis from the output register.
// s_axis_tready is low only while the output holds a stalled
// word and a second one sits in the skid register. Segment endpoints and radius are
// written through the cfg port (index 0..2 first endpoint x/y/z, 3..5 second endpoint
// x/y/z, 6 radius); write them only while no points are in flight.
module segment_proximity_point_filter #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // slave side, tdata: point_x, point_y, point_z from bit 0 up, zero padded
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // master side, tdata: out_x, out_y, out_z from bit 0 up, zero padded
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    // tuser: keep
    output logic                                    m_axis_tuser,
    // configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [spf_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [COORD_WIDTH-1:0]                  cfg_data
);

    import spf_pkg::*;

    localparam int N   = COORD_WIDTH;
    localparam int TDW = ((3 * N + 7) / 8) * 8;
    localparam int P   = 2 * N + 2;      // magnitude width into the wide multipliers
    localparam int QW  = 2 * P;          // wide product width
    localparam int SW  = QW + 2;         // sum of three squares
    localparam int XW  = 2 * N + 10;
    localparam int OW  = 3 * N + 1;      // skid word: point and keep

    // configuration registers
    logic signed [N-1:0] seg_a_reg [3];
    logic signed [N-1:0] seg_b_reg [3];
    logic [N-2:0]        radius_reg;

    logic                en;
    logic signed [N-1:0] pt_in [3];

    spf_ctl_t             ctl4;
    logic signed [N-1:0]  pt4 [3];
    logic signed [XW-1:0] dp20, lim_lo, lim_hi;
    logic [P-1:0]         c_abs [3];
    logic [P-1:0]         len2, rr;
    logic [QW-1:0]        sq [3];
    logic [QW-1:0]        rl;

    // stages 5..7 control and point
    logic                v5_reg, v6_reg, v7_reg;
    logic                cand5_reg, cand5_next, cand6_reg, cand7_reg;
    logic                origin5_reg, origin6_reg, origin7_reg;
    logic signed [N-1:0] pt5_reg [3], pt6_reg [3], pt7_reg [3];
    logic [SW-1:0]       cc7_reg, cc7_next;
    logic [QW-1:0]       rl7_reg;

    logic                keep;
    logic [OW-1:0]       skid_in, skid_out;

    // config writes are always taken; unknown indexes fall through
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_a_reg[0] <= N'(RST_START_X);
            seg_a_reg[1] <= N'(RST_START_Y);
            seg_a_reg[2] <= N'(RST_START_Z);
            seg_b_reg[0] <= N'(RST_END_X);
            seg_b_reg[1] <= N'(RST_END_Y);
            seg_b_reg[2] <= N'(RST_END_Z);
            radius_reg   <= (N-1)'(RST_RADIUS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_X: seg_a_reg[0] <= cfg_data;
                REG_START_Y: seg_a_reg[1] <= cfg_data;
                REG_START_Z: seg_a_reg[2] <= cfg_data;
                REG_END_X:   seg_b_reg[0] <= cfg_data;
                REG_END_Y:   seg_b_reg[1] <= cfg_data;
                REG_END_Z:   seg_b_reg[2] <= cfg_data;
                REG_RADIUS:  radius_reg   <= cfg_data[N-2:0];
                default:     ;
            endcase
        end
    end

    // whole pipeline moves whenever the skid stage can take a word
    assign s_axis_tready = en;

    assign pt_in[0] = s_axis_tdata[N-1:0];
    assign pt_in[1] = s_axis_tdata[2*N-1:N];
    assign pt_in[2] = s_axis_tdata[3*N-1:2*N];

    // stages 1..4: offsets, products, dot and cross products, window limits
    spf_geom #(
        .N (N)
    ) u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .pt       (pt_in),
        .seg_a    (seg_a_reg),
        .seg_b    (seg_b_reg),
        .radius   (radius_reg),
        .ctl      (ctl4),
        .pt_out   (pt4),
        .dp20     (dp20),
        .lim_lo   (lim_lo),
        .lim_hi   (lim_hi),
        .c_abs    (c_abs),
        .len2     (len2),
        .rr       (rr)
    );

    // stages 5..6: squared cross product terms and radius^2 * length^2
    for (genvar i = 0; i < 3; i++)
    begin : g_sq
        spf_wide_mul #(
            .W (P)
        ) u_sq (
            .clk (clk),
            .en  (en),
            .a   (c_abs[i]),
            .b   (c_abs[i]),
            .p   (sq[i])
        );
    end

    spf_wide_mul #(
        .W (P)
    ) u_rl (
        .clk (clk),
        .en  (en),
        .a   (rr),
        .b   (len2),
        .p   (rl)
    );

    // projection strictly inside the window, i.e. -3L < 20D < 23L
    assign cand5_next = (lim_lo < dp20) && (dp20 < lim_hi);

    // stage 7: squared distance times length^2 by lagrange identity
    assign cc7_next = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= ctl4.valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cand5_reg   <= cand5_next;
            origin5_reg <= ctl4.origin;
            pt5_reg     <= pt4;

            cand6_reg   <= cand5_reg;
            origin6_reg <= origin5_reg;
            pt6_reg     <= pt5_reg;

            cand7_reg   <= cand6_reg;
            origin7_reg <= origin6_reg;
            pt7_reg     <= pt6_reg;
            cc7_reg     <= cc7_next;
            rl7_reg     <= rl;
        end
    end

    // drop inside the window when close to the line or exactly the origin
    assign keep = !(cand7_reg && (origin7_reg || (cc7_reg <= SW'(rl7_reg))));

    assign skid_in = {keep, pt7_reg[2], pt7_reg[1], pt7_reg[0]};

    // output register and skid word
    spf_skid #(
        .W (OW)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v7_reg),
        .in_ready  (en),
        .in_data   (skid_in),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (skid_out)
    );

    assign m_axis_tdata = TDW'(skid_out[3*N-1:0]);
    assign m_axis_tuser = skid_out[3*N];

endmodule
